/* hdl/sslu_pkg.sv */
// ----------------------------------------------------------------------------
// sslu_pkg
// Shared constants for the server selection unit: table size, liveness
// defaults, result status codes, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package sslu_pkg;

  // table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // liveness defaults used when the matching register is zero
  localparam logic [15:0] DEFAULT_INTERVAL_SECONDS = 16'd30;
  localparam logic [7:0]  DEFAULT_MISSED_INTERVALS = 8'd3;

  // result status codes
  localparam logic [1:0] STATUS_WRITE_DONE = 2'd0;
  localparam logic [1:0] STATUS_CHOSEN     = 2'd1;
  localparam logic [1:0] STATUS_NONE       = 2'd2;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_CHOOSE = 1'b1;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_HEARTBEAT_SECONDS = 2'd0;
  localparam logic [1:0] REG_OFFLINE_INTERVALS = 2'd1;
  localparam logic [1:0] REG_DEFAULT_NAME_ID   = 2'd2;
  localparam logic [1:0] REG_DEFAULT_ENABLED   = 2'd3;

endpackage

/* hdl/server_selection_with_liveness_unit.sv */
// ----------------------------------------------------------------------------
// server_selection_with_liveness_unit
// Keeps a table of server slots and picks one server per choose request.
//
// Input channel (in_valid/in_ready): a write word fills one slot, a choose
// word asks for a server at time in_now_time, optionally by name id.
// Result channel (out_valid/out_ready): one word per input word, held in an
// output register, so a new input word can be taken while a result waits.
// Configuration goes through the APB-style port; the user must write it
// only while idle, as the block does not enforce it. A write word goes
// straight to the done state. A choose word passes the window multiply
// state, then the threshold subtract state, then the shared liveness and
// population compare walks the table one slot per cycle, then the done
// state loads the result. The block takes one word at a time and in_ready
// is low while a word is at work; it rises as the result is loaded into
// the output register. If the receiver stalls, a finished result waits in
// the done state until the output register is free. Reset clears all slot
// valid bits, the configuration registers and the output valid flag; there
// is no clearing pass.
// ----------------------------------------------------------------------------
module server_selection_with_liveness_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [3:0]  in_entry_index,
  input  logic        in_entry_valid,
  input  logic [15:0] in_entry_name_id,
  input  logic [31:0] in_entry_heartbeat,
  input  logic        in_entry_offline,
  input  logic        in_entry_full,
  input  logic [15:0] in_entry_population,
  input  logic        in_has_wanted,
  input  logic [15:0] in_wanted_id,
  input  logic [31:0] in_now_time,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_status,
  output logic [3:0]  out_chosen_index,
  output logic [15:0] out_chosen_name_id,
  output logic [15:0] out_chosen_population,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = sslu_pkg::SLOT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [SW-1:0] LAST_SLOT = SW'(sslu_pkg::TABLE_SLOTS - 1);

  // configuration registers
  logic [15:0] cfg_hb_seconds_r;
  logic [7:0]  cfg_intervals_r;
  logic [15:0] cfg_default_id_r;
  logic        cfg_default_en_r;

  // slot table
  logic [sslu_pkg::TABLE_SLOTS-1:0] slot_valid_r;
  logic [15:0] slot_name_r       [sslu_pkg::TABLE_SLOTS];
  logic [31:0] slot_heartbeat_r  [sslu_pkg::TABLE_SLOTS];
  logic        slot_offline_r    [sslu_pkg::TABLE_SLOTS];
  logic        slot_full_r       [sslu_pkg::TABLE_SLOTS];
  logic [15:0] slot_population_r [sslu_pkg::TABLE_SLOTS];

  // sequencer and per-request registers
  logic [2:0]    state_r;
  logic [SW-1:0] idx_r;
  logic          is_write_r;
  logic          has_wanted_r;
  logic          use_name_r;
  logic [15:0]   target_r;
  logic [31:0]   now_r;
  logic [23:0]   window_r;
  logic [31:0]   thr_r;
  logic          thr_neg_r;

  // scan results
  logic          name_found_r;
  logic [SW-1:0] name_idx_r;
  logic [15:0]   name_pop_r;
  logic          least_found_r;
  logic [SW-1:0] least_idx_r;
  logic [15:0]   least_name_r;
  logic [15:0]   least_pop_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_index_r;
  logic [15:0] out_name_r;
  logic [15:0] out_pop_r;

  logic          in_fire;
  logic          cfg_wr;
  logic          wr_in_range;
  logic [SW-1:0] wr_slot;
  logic [15:0]   secs_eff;
  logic [7:0]    ivs_eff;
  logic [32:0]   thr_diff;
  logic [31:0]   cur_hb;
  logic          cur_live;
  logic          name_hit;
  logic          least_hit;
  logic          scan_last;
  logic          out_load;
  logic [1:0]    res_status;
  logic [3:0]    res_index;
  logic [15:0]   res_name;
  logic [15:0]   res_pop;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign out_valid = out_valid_r;

  assign out_result_status     = out_status_r;
  assign out_chosen_index      = out_index_r;
  assign out_chosen_name_id    = out_name_r;
  assign out_chosen_population = out_pop_r;

  assign wr_in_range = (32'(in_entry_index) < sslu_pkg::TABLE_SLOTS);
  assign wr_slot     = SW'(in_entry_index);

  // zero registers fall back to the built-in defaults
  assign secs_eff = (cfg_hb_seconds_r == 16'd0) ? sslu_pkg::DEFAULT_INTERVAL_SECONDS
                                                : cfg_hb_seconds_r;
  assign ivs_eff  = (cfg_intervals_r == 8'd0) ? sslu_pkg::DEFAULT_MISSED_INTERVALS
                                              : cfg_intervals_r;

  // borrow out of the subtract means the threshold is below zero
  assign thr_diff = {1'b0, now_r} - {9'd0, window_r};

  // shared per-slot liveness and population compare
  assign cur_hb    = slot_heartbeat_r[idx_r];
  assign cur_live  = slot_valid_r[idx_r] && !slot_offline_r[idx_r] && (cur_hb != 32'd0) &&
                     (thr_neg_r || (cur_hb >= thr_r));
  assign name_hit  = cur_live && use_name_r && !name_found_r &&
                     (slot_name_r[idx_r] == target_r);
  assign least_hit = cur_live && !slot_full_r[idx_r] &&
                     (!least_found_r || (slot_population_r[idx_r] < least_pop_r));
  assign scan_last = (idx_r == LAST_SLOT);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    res_status = sslu_pkg::STATUS_NONE;
    res_index  = 4'd0;
    res_name   = 16'd0;
    res_pop    = 16'd0;
    if (is_write_r) begin
      res_status = sslu_pkg::STATUS_WRITE_DONE;
    end else if (use_name_r && name_found_r) begin
      res_status = sslu_pkg::STATUS_CHOSEN;
      res_index  = 4'(name_idx_r);
      res_name   = target_r;
      res_pop    = name_pop_r;
    end else if (!has_wanted_r && least_found_r) begin
      // unnamed request with no default hit takes the least loaded slot
      res_status = sslu_pkg::STATUS_CHOSEN;
      res_index  = 4'(least_idx_r);
      res_name   = least_name_r;
      res_pop    = least_pop_r;
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[3:2])
      sslu_pkg::REG_HEARTBEAT_SECONDS: prdata = {16'd0, cfg_hb_seconds_r};
      sslu_pkg::REG_OFFLINE_INTERVALS: prdata = {24'd0, cfg_intervals_r};
      sslu_pkg::REG_DEFAULT_NAME_ID:   prdata = {16'd0, cfg_default_id_r};
      sslu_pkg::REG_DEFAULT_ENABLED:   prdata = {31'd0, cfg_default_en_r};
      default:                         prdata = 32'd0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hb_seconds_r <= 16'd0;
      cfg_intervals_r  <= 8'd0;
      cfg_default_id_r <= 16'd0;
      cfg_default_en_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sslu_pkg::REG_HEARTBEAT_SECONDS: cfg_hb_seconds_r <= pwdata[15:0];
        sslu_pkg::REG_OFFLINE_INTERVALS: cfg_intervals_r  <= pwdata[7:0];
        sslu_pkg::REG_DEFAULT_NAME_ID:   cfg_default_id_r <= pwdata[15:0];
        sslu_pkg::REG_DEFAULT_ENABLED:   cfg_default_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (in_fire && (in_command == sslu_pkg::CMD_WRITE) && wr_in_range) begin
      slot_valid_r[wr_slot] <= in_entry_valid;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && (in_command == sslu_pkg::CMD_WRITE) && wr_in_range) begin
      slot_name_r[wr_slot]       <= in_entry_name_id;
      slot_heartbeat_r[wr_slot]  <= in_entry_heartbeat;
      slot_offline_r[wr_slot]    <= in_entry_offline;
      slot_full_r[wr_slot]       <= in_entry_full;
      slot_population_r[wr_slot] <= in_entry_population;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= (in_command == sslu_pkg::CMD_WRITE) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL:  state_r <= ST_SUB;
        ST_SUB:  state_r <= ST_SCAN;
        ST_SCAN: begin
          if (scan_last) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_write_r   <= (in_command == sslu_pkg::CMD_WRITE);
      has_wanted_r <= in_has_wanted;
      use_name_r   <= in_has_wanted || cfg_default_en_r;
      target_r     <= in_has_wanted ? in_wanted_id : cfg_default_id_r;
      now_r        <= in_now_time;
    end
    if (state_r == ST_MUL) begin
      window_r <= {8'd0, secs_eff} * {16'd0, ivs_eff};
    end
    if (state_r == ST_SUB) begin
      thr_r     <= thr_diff[31:0];
      thr_neg_r <= thr_diff[32];
    end
  end

  // scan counter and best-so-far registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      name_found_r  <= 1'b0;
      least_found_r <= 1'b0;
    end else if (state_r == ST_SUB) begin
      idx_r         <= '0;
      name_found_r  <= 1'b0;
      least_found_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      idx_r <= idx_r + SW'(1);
      if (name_hit) begin
        name_found_r <= 1'b1;
      end
      if (least_hit) begin
        least_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && name_hit) begin
      name_idx_r <= idx_r;
      name_pop_r <= slot_population_r[idx_r];
    end
    if ((state_r == ST_SCAN) && least_hit) begin
      least_idx_r  <= idx_r;
      least_name_r <= slot_name_r[idx_r];
      least_pop_r  <= slot_population_r[idx_r];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_name_r   <= res_name;
      out_pop_r    <= res_pop;
    end
  end

  // a taken word always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL) || (state_r == ST_DONE))
    else $error("accepted word did not start work");

  // the scan always starts at slot zero with cleared results
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUB) |=> (idx_r == '0) && !name_found_r && !least_found_r)
    else $error("scan started with stale state");

  // scan of the last slot ends the walk
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && scan_last |=> (state_r == ST_DONE))
    else $error("scan ran past the last slot");

  // a named hit points at a slot that is still valid
  a_name_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && !is_write_r && use_name_r && name_found_r |->
      slot_valid_r[name_idx_r])
    else $error("named hit on an empty slot");

  // a loaded result is never dropped before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_status_r))
    else $error("pending result lost");

endmodule

/* sim/tb_server_selection_with_liveness_unit.sv */
// ----------------------------------------------------------------------------
// tb_server_selection_with_liveness_unit
// Self-checking bench for the server selection unit. Table writes and choose
// requests go in through the input channel; a built-in predictor keeps its
// own copy of the slot table and the liveness settings, and every result
// word is checked field by field against the oldest predicted word.
// Directed cases cover the empty table, the table corners and the default
// server; random phases then sweep several liveness settings with random
// idling on both sides.
// ----------------------------------------------------------------------------
module tb_server_selection_with_liveness_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic        cmd;
    logic [3:0]  idx;
    logic        ent_valid;
    logic [15:0] name;
    logic [31:0] hb;
    logic        off;
    logic        full;
    logic [15:0] pop;
    logic        has_wanted;
    logic [15:0] wanted;
    logic [31:0] now;
  } server_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  index;
    logic [15:0] name;
    logic [15:0] pop;
  } server_pick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = sslu_pkg::CMD_WRITE;
  logic [3:0]  in_entry_index = '0;
  logic        in_entry_valid = 1'b0;
  logic [15:0] in_entry_name_id = '0;
  logic [31:0] in_entry_heartbeat = '0;
  logic        in_entry_offline = 1'b0;
  logic        in_entry_full = 1'b0;
  logic [15:0] in_entry_population = '0;
  logic        in_has_wanted = 1'b0;
  logic [15:0] in_wanted_id = '0;
  logic [31:0] in_now_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_status;
  logic [3:0]  out_chosen_index;
  logic [15:0] out_chosen_name_id;
  logic [15:0] out_chosen_population;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  server_selection_with_liveness_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_entry_index        (in_entry_index),
    .in_entry_valid        (in_entry_valid),
    .in_entry_name_id      (in_entry_name_id),
    .in_entry_heartbeat    (in_entry_heartbeat),
    .in_entry_offline      (in_entry_offline),
    .in_entry_full         (in_entry_full),
    .in_entry_population   (in_entry_population),
    .in_has_wanted         (in_has_wanted),
    .in_wanted_id          (in_wanted_id),
    .in_now_time           (in_now_time),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_result_status     (out_result_status),
    .out_chosen_index      (out_chosen_index),
    .out_chosen_name_id    (out_chosen_name_id),
    .out_chosen_population (out_chosen_population),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic        tbl_valid [sslu_pkg::TABLE_SLOTS];
  logic [15:0] tbl_name  [sslu_pkg::TABLE_SLOTS];
  logic [31:0] tbl_hb    [sslu_pkg::TABLE_SLOTS];
  logic        tbl_off   [sslu_pkg::TABLE_SLOTS];
  logic        tbl_full  [sslu_pkg::TABLE_SLOTS];
  logic [15:0] tbl_pop   [sslu_pkg::TABLE_SLOTS];
  logic [15:0] live_secs = '0;
  logic [7:0]  live_intervals = '0;
  logic [15:0] pref_name = '0;
  logic        pref_enabled = 1'b0;

  server_pick_t pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  logic        burst_mode = 1'b0;
  logic [31:0] epoch = '0;
  logic [15:0] name_pool [6];

  initial begin
    for (int s = 0; s < sslu_pkg::TABLE_SLOTS; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_name[s]  = '0;
      tbl_hb[s]    = '0;
      tbl_off[s]   = 1'b0;
      tbl_full[s]  = 1'b0;
      tbl_pop[s]   = '0;
    end
  end

  function automatic int unsigned live_window();
    int unsigned secs, ivs;
    secs = 32'((live_secs == 16'd0) ? sslu_pkg::DEFAULT_INTERVAL_SECONDS : live_secs);
    ivs  = 32'((live_intervals == 8'd0) ? sslu_pkg::DEFAULT_MISSED_INTERVALS
                                        : live_intervals);
    return secs * ivs;
  endfunction

  function automatic logic slot_is_live(int s, logic [31:0] now);
    longint oldest;
    oldest = longint'(now) - longint'(live_window());
    return tbl_valid[s] && !tbl_off[s] && (tbl_hb[s] != 32'd0) &&
           (longint'(tbl_hb[s]) >= oldest);
  endfunction

  function automatic int find_by_name(logic [15:0] id, logic [31:0] now);
    for (int s = 0; s < sslu_pkg::TABLE_SLOTS; s++)
      if (tbl_name[s] == id && slot_is_live(s, now)) return s;
    return -1;
  endfunction

  function automatic int find_least_loaded(logic [31:0] now);
    int best;
    best = -1;
    for (int s = 0; s < sslu_pkg::TABLE_SLOTS; s++) begin
      if (!slot_is_live(s, now) || tbl_full[s]) continue;
      if (best < 0 || tbl_pop[s] < tbl_pop[best]) best = s;
    end
    return best;
  endfunction

  function automatic server_pick_t predict_selection(server_req_t r);
    server_pick_t p;
    int pick;
    p.status = sslu_pkg::STATUS_WRITE_DONE;
    p.index  = '0;
    p.name   = '0;
    p.pop    = '0;
    pick     = -1;
    if (r.cmd == sslu_pkg::CMD_WRITE) begin
      tbl_valid[r.idx] = r.ent_valid;
      tbl_name[r.idx]  = r.name;
      tbl_hb[r.idx]    = r.hb;
      tbl_off[r.idx]   = r.off;
      tbl_full[r.idx]  = r.full;
      tbl_pop[r.idx]   = r.pop;
      return p;
    end
    if (r.has_wanted) begin
      pick = find_by_name(r.wanted, r.now);
    end else begin
      if (pref_enabled) pick = find_by_name(pref_name, r.now);
      if (pick < 0) pick = find_least_loaded(r.now);
    end
    if (pick < 0) begin
      p.status = sslu_pkg::STATUS_NONE;
    end else begin
      p.status = sslu_pkg::STATUS_CHOSEN;
      p.index  = pick[3:0];
      p.name   = tbl_name[pick];
      p.pop    = tbl_pop[pick];
    end
    return p;
  endfunction

  // every field random, the caller overrides what matters
  function automatic server_req_t random_req();
    server_req_t r;
    r.cmd        = 1'($urandom_range(0, 1));
    r.idx        = 4'($urandom_range(0, 15));
    r.ent_valid  = 1'($urandom_range(0, 1));
    r.name       = 16'($urandom);
    r.hb         = $urandom;
    r.off        = 1'($urandom_range(0, 1));
    r.full       = 1'($urandom_range(0, 1));
    r.pop        = 16'($urandom);
    r.has_wanted = 1'($urandom_range(0, 1));
    r.wanted     = 16'($urandom);
    r.now        = $urandom;
    return r;
  endfunction

  function automatic server_req_t slot_word(logic [3:0] idx, logic v, logic [15:0] name,
                                            logic [31:0] hb, logic off, logic full,
                                            logic [15:0] pop);
    server_req_t r;
    r = random_req();
    r.cmd = sslu_pkg::CMD_WRITE;
    r.idx = idx;
    r.ent_valid = v;
    r.name = name;
    r.hb = hb;
    r.off = off;
    r.full = full;
    r.pop = pop;
    return r;
  endfunction

  function automatic server_req_t choose_word(logic has, logic [15:0] id, logic [31:0] now);
    server_req_t r;
    r = random_req();
    r.cmd = sslu_pkg::CMD_CHOOSE;
    r.has_wanted = has;
    r.wanted = id;
    r.now = now;
    return r;
  endfunction

  task automatic send_word(input server_req_t r);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_command          <= r.cmd;
    in_entry_index      <= r.idx;
    in_entry_valid      <= r.ent_valid;
    in_entry_name_id    <= r.name;
    in_entry_heartbeat  <= r.hb;
    in_entry_offline    <= r.off;
    in_entry_full       <= r.full;
    in_entry_population <= r.pop;
    in_has_wanted       <= r.has_wanted;
    in_wanted_id        <= r.wanted;
    in_now_time         <= r.now;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.insert(pending_results.size(), predict_selection(r));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (sslu_pkg::TABLE_SLOTS + 8) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      sslu_pkg::REG_HEARTBEAT_SECONDS: live_secs      = value[15:0];
      sslu_pkg::REG_OFFLINE_INTERVALS: live_intervals = value[7:0];
      sslu_pkg::REG_DEFAULT_NAME_ID:   pref_name      = value[15:0];
      sslu_pkg::REG_DEFAULT_ENABLED:   pref_enabled   = value[0];
      default: ;
    endcase
  endtask

  // block must be idle before any register write
  task automatic configure(logic [15:0] secs, logic [7:0] ivs, logic [15:0] pref,
                           logic pref_on);
    drain_results();
    apb_write(sslu_pkg::REG_HEARTBEAT_SECONDS, {16'd0, secs});
    apb_write(sslu_pkg::REG_OFFLINE_INTERVALS, {24'd0, ivs});
    apb_write(sslu_pkg::REG_DEFAULT_NAME_ID, {16'd0, pref});
    apb_write(sslu_pkg::REG_DEFAULT_ENABLED, {31'd0, pref_on});
  endtask

  task automatic test_empty_table();
    send_word(choose_word(1'b0, 16'h0000, 32'd1000));
    send_word(choose_word(1'b1, 16'h0000, 32'd1000));
  endtask

  // default window is 90 s, so at now = 1000 the oldest live heartbeat is 910
  task automatic test_table_corners();
    send_word(slot_word(4'd0, 1'b1, 16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'hFFFF));
    send_word(slot_word(4'd15, 1'b1, 16'hFFFF, 32'd1000, 1'b0, 1'b0, 16'd5));
    send_word(slot_word(4'd7, 1'b1, 16'h1234, 32'd0, 1'b0, 1'b0, 16'd0));
    send_word(slot_word(4'd3, 1'b1, 16'h1234, 32'd990, 1'b1, 1'b0, 16'd0));
    send_word(slot_word(4'd5, 1'b1, 16'h1234, 32'd950, 1'b0, 1'b1, 16'd1));
    send_word(slot_word(4'd9, 1'b0, 16'h1234, 32'd1000, 1'b0, 1'b0, 16'd0));
    send_word(slot_word(4'd10, 1'b1, 16'h4321, 32'd909, 1'b0, 1'b0, 16'd2));
    send_word(choose_word(1'b0, 16'hABCD, 32'd1000));
    send_word(choose_word(1'b1, 16'h1234, 32'd1000));
    // stale by one second, no fallback to another slot
    send_word(choose_word(1'b1, 16'h4321, 32'd1000));
    send_word(choose_word(1'b1, 16'h4321, 32'd999));
    // window reaches below zero
    send_word(choose_word(1'b0, 16'h0000, 32'd50));
    // equal population, lower slot wins
    send_word(slot_word(4'd12, 1'b1, 16'h0777, 32'd1000, 1'b0, 1'b0, 16'd2));
    send_word(choose_word(1'b0, 16'h0000, 32'd50));
    send_word(choose_word(1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(choose_word(1'b1, 16'h0000, 32'hFFFF_FFFF));
  endtask

  task automatic test_default_server();
    configure(16'd0, 8'd0, 16'h1234, 1'b1);
    send_word(choose_word(1'b0, 16'h0000, 32'd1000));
    configure(16'd0, 8'd0, 16'h4321, 1'b1);
    send_word(choose_word(1'b0, 16'h0000, 32'd1000));
    send_word(choose_word(1'b1, 16'h1234, 32'd1000));
    configure(16'hFFFF, 8'hFF, 16'h0000, 1'b1);
    send_word(choose_word(1'b0, 16'h0000, 32'd20000000));
  endtask

  task automatic send_random_word();
    server_req_t r;
    int unsigned span;
    span = live_window();
    r = random_req();
    if ($urandom_range(0, 99) < 40) begin
      r.cmd       = sslu_pkg::CMD_WRITE;
      r.ent_valid = ($urandom_range(0, 99) < 85);
      r.name      = ($urandom_range(0, 9) == 0) ? 16'($urandom) : name_pool[$urandom_range(0, 5)];
      case ($urandom_range(0, 19))
        0:       r.hb = 32'd0;
        1:       r.hb = $urandom;
        2:       r.hb = epoch + $urandom_range(1, 1000);
        default: r.hb = epoch - $urandom_range(0, span + span / 2);
      endcase
      r.off  = ($urandom_range(0, 99) < 15);
      r.full = ($urandom_range(0, 99) < 25);
      r.pop  = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    end else begin
      r.cmd    = sslu_pkg::CMD_CHOOSE;
      r.wanted = ($urandom_range(0, 7) == 0) ? 16'($urandom) : name_pool[$urandom_range(0, 5)];
      r.now    = ($urandom_range(0, 19) == 0) ? $urandom : epoch + $urandom_range(0, span / 4);
    end
    send_word(r);
  endtask

  task automatic test_random_phase(logic [15:0] secs, logic [7:0] ivs, logic [15:0] pref,
                                   logic pref_on, int count);
    configure(secs, ivs, pref, pref_on);
    // a small epoch can put the liveness threshold below zero
    epoch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, live_window()) : $urandom;
    name_pool[0] = pref;
    for (int k = 1; k < 6; k++) name_pool[k] = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_random_word();
    end
    burst_mode = 1'b0;
  endtask

  // result side: random stall per word, then check against the oldest prediction
  initial begin : result_sink
    int stall;
    server_pick_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word status=%0d index=%0d name=%h pop=%0d", $time,
                 out_result_status, out_chosen_index, out_chosen_name_id,
                 out_chosen_population);
      end else begin
        want = pending_results.pop_front();
        if (out_result_status !== want.status || out_chosen_index !== want.index ||
            out_chosen_name_id !== want.name || out_chosen_population !== want.pop) begin
          error_count++;
          $display("%0t: mismatch expected status=%0d index=%0d name=%h pop=%0d", $time,
                   want.status, want.index, want.name, want.pop);
          $display("%0t:          actual   status=%0d index=%0d name=%h pop=%0d", $time,
                   out_result_status, out_chosen_index, out_chosen_name_id,
                   out_chosen_population);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_table_corners();
    test_default_server();
    test_random_phase(16'd0, 8'd0, 16'($urandom), 1'b0, 185);
    test_random_phase(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 185);
    test_random_phase(16'd1, 8'd1, 16'h0000, 1'b1, 185);
    test_random_phase(16'($urandom_range(1, 200)), 8'($urandom_range(1, 20)),
                      16'($urandom), 1'($urandom), 185);
    test_random_phase(16'($urandom), 8'd0, 16'($urandom), 1'b1, 185);
    drain_results();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sslu_pkg.sv
hdl/server_selection_with_liveness_unit.sv
sim/tb_server_selection_with_liveness_unit.sv
